FILE: src/bos_pkg.sv
// ----------------------------------------------------------------------------
// bos_pkg: shared types and constants for box overlap suppression
// Request and result structs, register indexes and store sizes.
// ----------------------------------------------------------------------------
package bos_pkg;

  // box store geometry
  localparam int unsigned MaxBoxes = 64;
  localparam int unsigned IdxW     = $clog2(MaxBoxes);
  localparam int unsigned CntW     = IdxW + 1;

  // configuration register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_MODE      = 1'b1;

  // reset values of the registers
  localparam logic [15:0] ThresholdReset = 16'd45875;

  // one input request
  typedef struct packed {
    logic signed [15:0] box_x1;
    logic signed [15:0] box_y1;
    logic signed [15:0] box_x2;
    logic signed [15:0] box_y2;
    logic        [15:0] score;
    logic               last_box;
  } box_req_t;

  // one result
  typedef struct packed {
    logic signed [15:0] kept_x1;
    logic signed [15:0] kept_y1;
    logic signed [15:0] kept_x2;
    logic signed [15:0] kept_y2;
    logic        [15:0] kept_score;
    logic        [5:0]  kept_index;
    logic               final_result;
    logic               overflow;
  } kept_res_t;

endpackage

FILE: src/box_overlap_suppression.sv
// ----------------------------------------------------------------------------
// box_overlap_suppression: greedy suppression of overlapping scored boxes
// Loads a set of boxes, runs the suppression pass with one shared
// multiplier under a sequencer, then returns the kept boxes in load order.
// ----------------------------------------------------------------------------
// Usage: boxes come in on the request channel (in_valid_i / in_ready_o),
// one per request. The request with last_box set is stored too and
// starts the pass; in_ready_o stays low until the last result of the
// set has been taken. Boxes beyond the store capacity are dropped and
// every result of that set carries overflow. The pass picks the best
// remaining box by scanning the store (one memory read port), then
// checks it against every other remaining box; the area, intersection
// and threshold products share one multiplier. Results leave from an
// output register (out_valid_o / out_ready_i); a stall simply holds the
// register, and the next kept box is read only after the previous
// result has been taken. Reset clears the set and loads the register
// reset values; the store contents need no clearing. Registers are
// written over cfg_we_i; the user is to write them only while the block
// is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module box_overlap_suppression (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bos_pkg::box_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bos_pkg::kept_res_t  out_res_o
);
  import bos_pkg::*;

  typedef enum logic [18:0] {
    ST_IDLE     = 19'd1 << 0,
    ST_SEL_ADDR = 19'd1 << 1,
    ST_SEL_CHK  = 19'd1 << 2,
    ST_SEL_DONE = 19'd1 << 3,
    ST_A_ADDR   = 19'd1 << 4,
    ST_A_LD     = 19'd1 << 5,
    ST_A_MUL    = 19'd1 << 6,
    ST_A_AREA   = 19'd1 << 7,
    ST_PB_ADDR  = 19'd1 << 8,
    ST_PB_LD    = 19'd1 << 9,
    ST_PB_OV    = 19'd1 << 10,
    ST_PB_MI    = 19'd1 << 11,
    ST_PB_MA    = 19'd1 << 12,
    ST_PB_DEN   = 19'd1 << 13,
    ST_PB_MT    = 19'd1 << 14,
    ST_PB_CMP   = 19'd1 << 15,
    ST_E_ADDR   = 19'd1 << 16,
    ST_E_LD     = 19'd1 << 17,
    ST_E_WAIT   = 19'd1 << 18
  } state_e;

  state_e               state_q, state_d;
  logic [15:0]          thr_q;
  logic                 mode_q;
  logic [CntW-1:0]      count_q;
  logic                 dropped_q;
  logic [MaxBoxes-1:0]  supp_q, visited_q;
  logic [IdxW-1:0]      idx_q, best_q, rd_addr;
  logic                 best_valid_q;
  logic [15:0]          best_score_q;
  box_req_t             mem [MaxBoxes];
  box_req_t             rdata_q, a_q, b_q;
  logic [15:0]          ovx_q, ovy_q;
  logic signed [33:0]   area_a_q;
  logic [31:0]          inter_q;
  logic signed [34:0]   den_q;
  logic signed [16:0]   op_a;
  logic signed [34:0]   op_b;
  logic signed [51:0]   mul_q;
  logic                 out_valid_q;
  kept_res_t            out_q;
  logic                 in_acc, out_acc, idx_last, eligible, is_final;
  logic signed [16:0]   adx, ady, bdx, bdy;
  logic signed [33:0]   area_b;
  logic signed [34:0]   den_sum, den_min;
  logic [MaxBoxes-1:0]  remaining;

  // overlap along one axis, floored at zero
  function automatic logic [15:0] axis_ov(logic signed [15:0] a1, logic signed [15:0] a2,
                                          logic signed [15:0] b1, logic signed [15:0] b2);
    logic signed [15:0] lo, hi;
    logic signed [16:0] d;
    lo = (a1 > b1) ? a1 : b1;
    hi = (a2 < b2) ? a2 : b2;
    d  = {hi[15], hi} - {lo[15], lo};
    return (d > 17'sd0) ? d[15:0] : 16'd0;
  endfunction

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_acc     = out_valid_q && out_ready_i;
  assign idx_last    = ({1'b0, idx_q} == count_q - CntW'(1));
  assign eligible    = !visited_q[idx_q] && !supp_q[idx_q];

  // edge differences
  assign adx = {a_q.box_x2[15], a_q.box_x2} - {a_q.box_x1[15], a_q.box_x1};
  assign ady = {a_q.box_y2[15], a_q.box_y2} - {a_q.box_y1[15], a_q.box_y1};
  assign bdx = {b_q.box_x2[15], b_q.box_x2} - {b_q.box_x1[15], b_q.box_x1};
  assign bdy = {b_q.box_y2[15], b_q.box_y2} - {b_q.box_y1[15], b_q.box_y1};

  // denominator candidates
  assign area_b  = mul_q[33:0];
  assign den_sum = {area_a_q[33], area_a_q} + {area_b[33], area_b} - {3'b000, inter_q};
  assign den_min = (area_a_q < area_b) ? {area_a_q[33], area_a_q} : {area_b[33], area_b};

  // any kept box after the current one
  always_comb begin
    for (int m = 0; m < MaxBoxes; m++) begin
      remaining[m] = !supp_q[m] && (CntW'(m) < count_q) && (IdxW'(m) > idx_q);
    end
    is_final = (remaining == '0);
  end

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      ST_A_MUL: begin
        op_a = adx;
        op_b = {{18{ady[16]}}, ady};
      end
      ST_PB_MI: begin
        op_a = $signed({1'b0, ovx_q});
        op_b = $signed({19'd0, ovy_q});
      end
      ST_PB_MA: begin
        op_a = bdx;
        op_b = {{18{bdy[16]}}, bdy};
      end
      ST_PB_MT: begin
        op_a = $signed({1'b0, thr_q});
        op_b = den_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // memory read address
  always_comb begin
    rd_addr = (state_q == ST_A_ADDR) ? best_q : idx_q;
  end

  // box store
  always_ff @(posedge clk_i) begin
    if (in_acc && (count_q < CntW'(MaxBoxes))) begin
      mem[count_q[IdxW-1:0]] <= in_req_i;
    end
    rdata_q <= mem[rd_addr];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= op_a * op_b;
    if (state_q == ST_A_LD)   a_q <= rdata_q;
    if (state_q == ST_A_AREA) area_a_q <= mul_q[33:0];
    if (state_q == ST_PB_LD)  b_q <= rdata_q;
    if (state_q == ST_PB_OV) begin
      ovx_q <= axis_ov(a_q.box_x1, a_q.box_x2, b_q.box_x1, b_q.box_x2);
      ovy_q <= axis_ov(a_q.box_y1, a_q.box_y2, b_q.box_y1, b_q.box_y2);
    end
    if (state_q == ST_PB_MA)  inter_q <= mul_q[31:0];
    if (state_q == ST_PB_DEN) den_q <= mode_q ? den_min : den_sum;
    if (state_q == ST_E_LD) begin
      out_q.kept_x1      <= rdata_q.box_x1;
      out_q.kept_y1      <= rdata_q.box_y1;
      out_q.kept_x2      <= rdata_q.box_x2;
      out_q.kept_y2      <= rdata_q.box_y2;
      out_q.kept_score   <= rdata_q.score;
      out_q.kept_index   <= 6'(idx_q);
      out_q.final_result <= is_final;
      out_q.overflow     <= dropped_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_acc && in_req_i.last_box) state_d = ST_SEL_ADDR;
      ST_SEL_ADDR: begin
        if (eligible && ({1'b0, idx_q} < count_q)) state_d = ST_SEL_CHK;
        else if (idx_last) state_d = ST_SEL_DONE;
      end
      ST_SEL_CHK:  state_d = idx_last ? ST_SEL_DONE : ST_SEL_ADDR;
      ST_SEL_DONE: state_d = best_valid_q ? ST_A_ADDR : ST_E_ADDR;
      ST_A_ADDR:   state_d = ST_A_LD;
      ST_A_LD:     state_d = ST_A_MUL;
      ST_A_MUL:    state_d = ST_A_AREA;
      ST_A_AREA:   state_d = ST_PB_ADDR;
      ST_PB_ADDR: begin
        if (eligible) state_d = ST_PB_LD;
        else if (idx_last) state_d = ST_SEL_ADDR;
      end
      ST_PB_LD:    state_d = ST_PB_OV;
      ST_PB_OV:    state_d = ST_PB_MI;
      ST_PB_MI:    state_d = ST_PB_MA;
      ST_PB_MA:    state_d = ST_PB_DEN;
      ST_PB_DEN:   state_d = ST_PB_MT;
      ST_PB_MT:    state_d = ST_PB_CMP;
      ST_PB_CMP:   state_d = idx_last ? ST_SEL_ADDR : ST_PB_ADDR;
      ST_E_ADDR:   if (!supp_q[idx_q]) state_d = ST_E_LD;
      ST_E_LD:     state_d = ST_E_WAIT;
      ST_E_WAIT: begin
        if (out_acc) state_d = out_q.final_result ? ST_IDLE : ST_E_ADDR;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      thr_q        <= ThresholdReset;
      mode_q       <= 1'b0;
      count_q      <= '0;
      dropped_q    <= 1'b0;
      supp_q       <= '0;
      visited_q    <= '0;
      idx_q        <= '0;
      best_q       <= '0;
      best_valid_q <= 1'b0;
      best_score_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_THRESHOLD: thr_q  <= cfg_data_i;
          CFG_MODE:      mode_q <= cfg_data_i[0];
          default:       thr_q  <= thr_q;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (count_q < CntW'(MaxBoxes)) count_q <= count_q + CntW'(1);
            else dropped_q <= 1'b1;
            idx_q        <= '0;
            best_valid_q <= 1'b0;
            supp_q       <= '0;
            visited_q    <= '0;
          end
        end
        ST_SEL_ADDR: begin
          if (!(eligible && ({1'b0, idx_q} < count_q)) && !idx_last) idx_q <= idx_q + IdxW'(1);
        end
        // highest score wins, ties keep the lower index
        ST_SEL_CHK: begin
          if (!best_valid_q || (rdata_q.score > best_score_q)) begin
            best_valid_q <= 1'b1;
            best_q       <= idx_q;
            best_score_q <= rdata_q.score;
          end
          if (!idx_last) idx_q <= idx_q + IdxW'(1);
        end
        ST_SEL_DONE: begin
          idx_q <= '0;
          if (best_valid_q) visited_q[best_q] <= 1'b1;
        end
        ST_A_AREA: idx_q <= '0;
        ST_PB_ADDR: begin
          if (!eligible) begin
            if (idx_last) begin
              idx_q        <= '0;
              best_valid_q <= 1'b0;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
          end
        end
        // suppress when the scaled intersection beats the threshold
        ST_PB_CMP: begin
          if ((den_q > 35'sd0) && ($signed({4'd0, inter_q, 16'd0}) > mul_q)) begin
            supp_q[idx_q] <= 1'b1;
          end
          if (idx_last) begin
            idx_q        <= '0;
            best_valid_q <= 1'b0;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        ST_E_ADDR: if (supp_q[idx_q]) idx_q <= idx_q + IdxW'(1);
        ST_E_LD:   out_valid_q <= 1'b1;
        ST_E_WAIT: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            if (out_q.final_result) begin
              count_q   <= '0;
              dropped_q <= 1'b0;
              supp_q    <= '0;
              visited_q <= '0;
              idx_q     <= '0;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
          end
        end
        default: idx_q <= idx_q;
      endcase
    end
  end

endmodule

FILE: src/bos_checker.sv
// ----------------------------------------------------------------------------
// bos_checker: port-level checks for box overlap suppression
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module bos_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input bos_pkg::box_req_t  in_req_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bos_pkg::kept_res_t out_res_o
);
  import bos_pkg::*;

  // never loading while results are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request accepted while results pending");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  // the closing request starts the pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.last_box |=> !in_ready_o)
    else $error("pass did not start");

  // other requests only load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_req_i.last_box |=> in_ready_o)
    else $error("load request left idle");

  // the final result frees the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_res_o.final_result |=> in_ready_o && !out_valid_o)
    else $error("block not idle after final result");

endmodule

bind box_overlap_suppression bos_checker u_bos_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_res_o   (out_res_o)
);
